/* rtl/pausable_media_reference_clock_macros.svh */
// Assertion macros for the pausable media reference clock
`ifndef PAUSABLE_MEDIA_REFERENCE_CLOCK_MACROS_SVH
`define PAUSABLE_MEDIA_REFERENCE_CLOCK_MACROS_SVH

// check a property on every edge outside reset
`define PMRC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition leads to a result on the next edge
`define PMRC_ASSERT_NEXT(label, clk, rst_n, cond, res, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) else $error(msg);

`endif

/* rtl/pmrc_pkg.sv */
// Package: types and constants of the pausable media reference clock
package pmrc_pkg;

  localparam int TIME_BITS_DEF = 48;
  localparam int NOW_BITS      = 48;
  localparam int OUT_BITS      = 48;
  localparam int CMD_BITS      = 4;
  localparam int FLAG_COUNT    = 6;

  localparam int FLAG_STARTED = 0;
  localparam int FLAG_PLAYING = 1;
  localparam int FLAG_PAUSED  = 2;
  localparam int FLAG_WAITING = 3;
  localparam int FLAG_SEEKED  = 4;
  localparam int FLAG_NONE    = 5;

  typedef logic [FLAG_COUNT-1:0] flags_t;

  localparam flags_t FLAGS_RESET = flags_t'(1) << FLAG_NONE;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_PLAY         = 4'd0,
    CMD_PAUSE        = 4'd1,
    CMD_BEGIN_WAIT   = 4'd2,
    CMD_END_WAIT     = 4'd3,
    CMD_CANCEL_WAIT  = 4'd4,
    CMD_SEEK         = 4'd5,
    CMD_RESET        = 4'd6,
    CMD_RELOAD_START = 4'd7,
    CMD_QUERY        = 4'd8
  } cmd_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] elapsed_ms;
    logic                       started;
    logic                       playing;
    logic                       paused;
    logic                       waiting;
    logic                       seeked;
    logic [OUT_BITS-1:0]        start_ms;
  } result_t;

endpackage

/* rtl/pmrc_if.sv */
// Interfaces: command channel and result channel
interface pmrc_in_if;
  logic                               valid;
  logic                               ready;
  logic [pmrc_pkg::CMD_BITS-1:0]      command;
  logic [pmrc_pkg::NOW_BITS-1:0]      now_ms;

  modport source (output valid, command, now_ms, input ready);
  modport sink (input valid, command, now_ms, output ready);
endinterface

interface pmrc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pmrc_pkg::OUT_BITS-1:0] elapsed_ms;
  logic                               started;
  logic                               playing;
  logic                               paused;
  logic                               waiting;
  logic                               seeked;
  logic [pmrc_pkg::OUT_BITS-1:0]      start_ms;

  modport source (output valid, elapsed_ms, started, playing, paused, waiting, seeked,
                  start_ms, input ready);
  modport sink (input valid, elapsed_ms, started, playing, paused, waiting, seeked,
                start_ms, output ready);
endinterface

/* rtl/pausable_media_reference_clock.sv */
// Top level: pausable media reference clock with command and result channels
//
//   channel  dir  handshake     words
//   in_ch    in   valid/ready   command, now_ms
//   out_ch   out  valid/ready   elapsed_ms, flags, start_ms
//
// One word per cycle while in_ch.ready is high; results are registered.
// State updates and the result are computed in one pass from the state registers.
// An output register plus a one-word skid stage take one more word when out_ch stalls;
// in_ch.ready then stays low until the skid word moves to the output register.
// rst_n (synchronous) sets flags to none only, zeroes both stamps, empties both stages.
`include "pausable_media_reference_clock_macros.svh"

module pausable_media_reference_clock #(
  parameter int TIME_BITS = pmrc_pkg::TIME_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pmrc_in_if.sink    in_ch,
  pmrc_out_if.source out_ch
);

  typedef logic [TIME_BITS-1:0] time_t;

  pmrc_pkg::flags_t  flags_r, flags_nxt;
  time_t             start_r, start_nxt;
  time_t             pause_r, pause_nxt;
  time_t             now_w;
  time_t             elapsed_w;
  pmrc_pkg::result_t res_w;
  pmrc_pkg::result_t out_data_r, skid_data_r;
  logic              out_valid_r, skid_valid_r;
  logic              in_acc;

  assign in_ch.ready = !skid_valid_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign now_w       = TIME_BITS'(in_ch.now_ms);

  always_comb begin
    flags_nxt = flags_r;
    start_nxt = start_r;
    pause_nxt = pause_r;
    case (pmrc_pkg::cmd_t'(in_ch.command))
      pmrc_pkg::CMD_PLAY: begin
        if (!flags_r[pmrc_pkg::FLAG_STARTED]) begin
          start_nxt = now_w;
          flags_nxt[pmrc_pkg::FLAG_STARTED] = 1'b1;
          flags_nxt[pmrc_pkg::FLAG_PLAYING] = 1'b1;
          flags_nxt[pmrc_pkg::FLAG_NONE]    = 1'b0;
        end else if (flags_r[pmrc_pkg::FLAG_PAUSED]) begin
          if (!flags_r[pmrc_pkg::FLAG_WAITING]) begin
            if (flags_r[pmrc_pkg::FLAG_SEEKED]) begin
              start_nxt = now_w;
              flags_nxt[pmrc_pkg::FLAG_SEEKED] = 1'b0;
            end else begin
              start_nxt = now_w - pause_r + start_r;
            end
            flags_nxt[pmrc_pkg::FLAG_NONE] = 1'b0;
          end
          flags_nxt[pmrc_pkg::FLAG_PLAYING] = 1'b1;
          flags_nxt[pmrc_pkg::FLAG_PAUSED]  = 1'b0;
        end
      end
      pmrc_pkg::CMD_PAUSE: begin
        if (!flags_r[pmrc_pkg::FLAG_WAITING]) begin
          pause_nxt = now_w;
        end
        flags_nxt[pmrc_pkg::FLAG_PAUSED]  = 1'b1;
        flags_nxt[pmrc_pkg::FLAG_PLAYING] = 1'b0;
      end
      pmrc_pkg::CMD_BEGIN_WAIT: begin
        if (!flags_r[pmrc_pkg::FLAG_STARTED]) begin
          pause_nxt = now_w;
          start_nxt = now_w;
          flags_nxt[pmrc_pkg::FLAG_STARTED] = 1'b1;
          flags_nxt[pmrc_pkg::FLAG_WAITING] = 1'b1;
          flags_nxt[pmrc_pkg::FLAG_NONE]    = 1'b0;
        end else begin
          if (!flags_r[pmrc_pkg::FLAG_PAUSED]) begin
            pause_nxt = now_w;
          end
          flags_nxt[pmrc_pkg::FLAG_WAITING] = 1'b1;
        end
      end
      pmrc_pkg::CMD_END_WAIT: begin
        if (flags_r[pmrc_pkg::FLAG_WAITING]) begin
          if (!flags_r[pmrc_pkg::FLAG_PAUSED]) begin
            if (flags_r[pmrc_pkg::FLAG_SEEKED]) begin
              start_nxt = now_w;
              flags_nxt[pmrc_pkg::FLAG_SEEKED] = 1'b0;
            end else begin
              start_nxt = now_w - pause_r + start_r;
            end
            flags_nxt[pmrc_pkg::FLAG_STARTED] = 1'b1;
            flags_nxt[pmrc_pkg::FLAG_NONE]    = 1'b0;
          end
          flags_nxt[pmrc_pkg::FLAG_WAITING] = 1'b0;
        end
      end
      pmrc_pkg::CMD_CANCEL_WAIT: begin
        flags_nxt[pmrc_pkg::FLAG_WAITING] = 1'b0;
      end
      pmrc_pkg::CMD_SEEK: begin
        if (flags_r[pmrc_pkg::FLAG_PAUSED] || flags_r[pmrc_pkg::FLAG_WAITING]) begin
          start_nxt = pause_r;
          flags_nxt[pmrc_pkg::FLAG_SEEKED] = 1'b1;
        end else begin
          start_nxt = now_w;
        end
        flags_nxt[pmrc_pkg::FLAG_STARTED] = 1'b1;
        flags_nxt[pmrc_pkg::FLAG_NONE]    = 1'b0;
      end
      pmrc_pkg::CMD_RESET: begin
        flags_nxt = pmrc_pkg::FLAGS_RESET;
        start_nxt = '0;
        pause_nxt = '0;
      end
      pmrc_pkg::CMD_RELOAD_START: begin
        start_nxt = now_w;
        flags_nxt[pmrc_pkg::FLAG_STARTED] = 1'b1;
        flags_nxt[pmrc_pkg::FLAG_NONE]    = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (!flags_nxt[pmrc_pkg::FLAG_STARTED]) begin
      elapsed_w = '0;
    end else if (flags_nxt[pmrc_pkg::FLAG_PAUSED] || flags_nxt[pmrc_pkg::FLAG_WAITING]) begin
      elapsed_w = pause_nxt - start_nxt;
    end else begin
      elapsed_w = now_w - start_nxt;
    end
    res_w.elapsed_ms = pmrc_pkg::OUT_BITS'(elapsed_w);
    res_w.started    = flags_nxt[pmrc_pkg::FLAG_STARTED];
    res_w.playing    = flags_nxt[pmrc_pkg::FLAG_PLAYING];
    res_w.paused     = flags_nxt[pmrc_pkg::FLAG_PAUSED];
    res_w.waiting    = flags_nxt[pmrc_pkg::FLAG_WAITING];
    res_w.seeked     = flags_nxt[pmrc_pkg::FLAG_SEEKED];
    res_w.start_ms   = pmrc_pkg::OUT_BITS'(start_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= pmrc_pkg::FLAGS_RESET;
      start_r <= '0;
      pause_r <= '0;
    end else if (in_acc) begin
      flags_r <= flags_nxt;
      start_r <= start_nxt;
      pause_r <= pause_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_acc) begin
        out_data_r <= res_w;
      end
    end else if (in_acc) begin
      skid_data_r <= res_w;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.elapsed_ms = out_data_r.elapsed_ms;
  assign out_ch.started    = out_data_r.started;
  assign out_ch.playing    = out_data_r.playing;
  assign out_ch.paused     = out_data_r.paused;
  assign out_ch.waiting    = out_data_r.waiting;
  assign out_ch.seeked     = out_data_r.seeked;
  assign out_ch.start_ms   = out_data_r.start_ms;

  `PMRC_ASSERT(a_skid_behind_out, clk, rst_n,
               !skid_valid_r || out_valid_r, "skid word without output word")
  `PMRC_ASSERT(a_started_not_none, clk, rst_n,
               flags_r[pmrc_pkg::FLAG_STARTED] != flags_r[pmrc_pkg::FLAG_NONE],
               "started and none flags disagree")
  `PMRC_ASSERT(a_seeked_started, clk, rst_n,
               !flags_r[pmrc_pkg::FLAG_SEEKED] || flags_r[pmrc_pkg::FLAG_STARTED],
               "seek pending while not started")
  `PMRC_ASSERT_NEXT(a_stall_fills_skid, clk, rst_n,
                    in_acc && out_valid_r && !out_ch.ready, skid_valid_r,
                    "stalled word not held in skid")

endmodule
